@@ hdl/bsgf_pkg.sv @@
// shared types, constants and state encoding for the body section gap finder
package bsgf_pkg;

    // default sizes of the tables
    localparam int SECTIONS_DEF = 64;
    localparam int BODIES_DEF   = 256;
    localparam int SEGMENTS_DEF = 1024;

    // field widths of a transaction
    localparam int ACT_FW  = 2;
    localparam int SEC_FW  = 6;
    localparam int SEG_FW  = 10;
    localparam int BODY_FW = 8;

    // action codes
    localparam logic [ACT_FW-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACT_FW-1:0] ACT_RECORD = 2'd1;
    localparam logic [ACT_FW-1:0] ACT_QUERY  = 2'd2;

    // input transaction
    typedef struct packed {
        logic [ACT_FW-1:0]  action;
        logic [SEC_FW-1:0]  section;
        logic [SEG_FW-1:0]  segment_id;
        logic [BODY_FW-1:0] body_id;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [SEC_FW-1:0]  gap_section;
        logic [BODY_FW-1:0] gap_body;
        logic               gap_found;
        logic               last;
    } out_item_t;

    // memory port controls from the sequencer
    typedef struct packed {
        logic seg_we;
        logic seg_re;
        logic body_we;
        logic body_re;
    } mem_ctl_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SEG_RD,
        ST_BODY_RD,
        ST_UPDATE,
        ST_Q_RD,
        ST_Q_CHK,
        ST_SCAN,
        ST_FIN
    } state_t;

endpackage

@@ hdl/bsgf_mem.sv @@
// segment-to-body table and per-body section record memories
module bsgf_mem #(
    parameter int SECTIONS = bsgf_pkg::SECTIONS_DEF,
    parameter int BODIES   = bsgf_pkg::BODIES_DEF,
    parameter int SEGMENTS = bsgf_pkg::SEGMENTS_DEF
) (
    input  logic                                           clk,
    input  bsgf_pkg::mem_ctl_t                             ctl,
    input  logic [$clog2(SEGMENTS)-1:0]                    seg_addr,
    input  logic [bsgf_pkg::BODY_FW-1:0]                   seg_wdata,
    output logic [bsgf_pkg::BODY_FW-1:0]                   seg_rdata,
    input  logic [$clog2(BODIES)-1:0]                      body_addr,
    input  logic [SECTIONS+2*bsgf_pkg::SEC_FW:0]           body_wdata,
    output logic [SECTIONS+2*bsgf_pkg::SEC_FW:0]           body_rdata
);
    import bsgf_pkg::*;

    localparam int ENT_W = SECTIONS + 2 * SEC_FW + 1;

    logic [BODY_FW-1:0] seg_mem  [SEGMENTS];
    logic [ENT_W-1:0]   body_mem [BODIES];

    // segment table, single port
    always_ff @(posedge clk)
    begin
        if (ctl.seg_we)
        begin
            seg_mem[seg_addr] <= seg_wdata;
        end
        if (ctl.seg_re)
        begin
            seg_rdata <= seg_mem[seg_addr];
        end
    end

    // body records: seen flag, lowest, highest, presence bits
    always_ff @(posedge clk)
    begin
        if (ctl.body_we)
        begin
            body_mem[body_addr] <= body_wdata;
        end
        if (ctl.body_re)
        begin
            body_rdata <= body_mem[body_addr];
        end
    end

endmodule

@@ hdl/bsgf_ctrl.sv @@
// sequencer with the shared section scan and range update unit
module bsgf_ctrl #(
    parameter int SECTIONS = bsgf_pkg::SECTIONS_DEF,
    parameter int BODIES   = bsgf_pkg::BODIES_DEF,
    parameter int SEGMENTS = bsgf_pkg::SEGMENTS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           item_valid,
    output logic                                           item_stall,
    input  bsgf_pkg::in_item_t                             item,
    output logic                                           res_valid,
    input  logic                                           res_ready,
    output bsgf_pkg::out_item_t                            res,
    output bsgf_pkg::mem_ctl_t                             mem_ctl,
    output logic [$clog2(SEGMENTS)-1:0]                    seg_addr,
    output logic [bsgf_pkg::BODY_FW-1:0]                   seg_wdata,
    input  logic [bsgf_pkg::BODY_FW-1:0]                   seg_rdata,
    output logic [$clog2(BODIES)-1:0]                      body_addr,
    output logic [SECTIONS+2*bsgf_pkg::SEC_FW:0]           body_wdata,
    input  logic [SECTIONS+2*bsgf_pkg::SEC_FW:0]           body_rdata
);
    import bsgf_pkg::*;

    localparam int SEG_AW    = $clog2(SEGMENTS);
    localparam int BODY_AW   = $clog2(BODIES);
    localparam int SEC_W     = $clog2(SECTIONS);
    localparam int ENT_W     = SECTIONS + 2 * SEC_FW + 1;
    localparam int CLR_DEPTH = (SEGMENTS > BODIES) ? SEGMENTS : BODIES;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    state_t state_reg, state_next;

    logic [CLR_AW-1:0]   clr_cnt_reg;
    in_item_t            item_reg;
    logic [BODY_AW-1:0]  body_idx_reg;
    logic [SECTIONS-1:0] bits_reg;
    logic [SEC_FW-1:0]   z_reg;
    logic [SEC_FW-1:0]   hi_reg;
    logic [SEC_FW-1:0]   pend_reg;
    logic                pend_valid_reg;

    // fields of the record read back
    logic                ent_seen;
    logic [SEC_FW-1:0]   ent_lo;
    logic [SEC_FW-1:0]   ent_hi;
    logic [SECTIONS-1:0] ent_bits;

    logic                seg_ok;
    logic [BODY_FW-1:0]  rec_body;
    logic                rec_ok;
    logic                q_ok;
    logic                q_hit;
    logic [SECTIONS-1:0] sec_bit;
    logic [SECTIONS-1:0] new_bits;
    logic [SEC_FW-1:0]   new_lo;
    logic [SEC_FW-1:0]   new_hi;
    logic                gap;
    logic                step_go;
    logic                clr_done;

    assign ent_seen = body_rdata[ENT_W-1];
    assign ent_lo   = body_rdata[ENT_W-2 -: SEC_FW];
    assign ent_hi   = body_rdata[ENT_W-2-SEC_FW -: SEC_FW];
    assign ent_bits = body_rdata[SECTIONS-1:0];

    // range checks and record lookup
    assign seg_ok   = 32'(item_reg.segment_id) < 32'(SEGMENTS);
    assign rec_body = seg_ok ? seg_rdata : '0;
    assign rec_ok   = (32'(item_reg.section) < 32'(SECTIONS))
                      && (32'(rec_body) < 32'(BODIES));
    assign q_ok     = 32'(item_reg.body_id) < 32'(BODIES);
    assign q_hit    = q_ok && ent_seen;

    // record update: set presence bit, widen the range
    assign sec_bit  = {{(SECTIONS-1){1'b0}}, 1'b1} << item_reg.section;
    assign new_bits = (ent_seen ? ent_bits : '0) | sec_bit;
    assign new_lo   = (!ent_seen || item_reg.section < ent_lo) ? item_reg.section : ent_lo;
    assign new_hi   = (!ent_seen || item_reg.section > ent_hi) ? item_reg.section : ent_hi;

    // scan step: a gap found while one is pending pushes the pending one out
    assign gap      = !bits_reg[z_reg[SEC_W-1:0]];
    assign step_go  = !(gap && pend_valid_reg) || res_ready;
    assign clr_done = clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.action)
                        ACT_LOAD:   state_next = ST_LOAD;
                        ACT_RECORD: state_next = ST_SEG_RD;
                        ACT_QUERY:  state_next = ST_Q_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:    state_next = ST_IDLE;
            ST_SEG_RD:  state_next = ST_BODY_RD;
            ST_BODY_RD: state_next = rec_ok ? ST_UPDATE : ST_IDLE;
            ST_UPDATE:  state_next = ST_IDLE;
            ST_Q_RD:    state_next = ST_Q_CHK;
            ST_Q_CHK:   state_next = q_hit ? ST_SCAN : ST_FIN;
            ST_SCAN:
            begin
                if (step_go && z_reg == hi_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs per state
    always_comb
    begin
        item_stall = 1'b1;
        mem_ctl    = '0;
        seg_addr   = SEG_AW'(item_reg.segment_id);
        seg_wdata  = item_reg.body_id;
        body_addr  = BODY_AW'(item_reg.body_id);
        body_wdata = {1'b1, new_lo, new_hi, new_bits};
        res_valid  = 1'b0;
        res        = '{gap_section: pend_reg, gap_body: item_reg.body_id,
                       gap_found: 1'b1, last: 1'b0};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.seg_we  = 32'(clr_cnt_reg) < 32'(SEGMENTS);
                mem_ctl.body_we = 32'(clr_cnt_reg) < 32'(BODIES);
                seg_addr        = clr_cnt_reg[SEG_AW-1:0];
                seg_wdata       = '0;
                body_addr       = clr_cnt_reg[BODY_AW-1:0];
                body_wdata      = '0;
            end
            ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            ST_LOAD:
            begin
                mem_ctl.seg_we = seg_ok;
            end
            ST_SEG_RD:
            begin
                mem_ctl.seg_re = 1'b1;
            end
            ST_BODY_RD:
            begin
                mem_ctl.body_re = rec_ok;
                body_addr       = BODY_AW'(rec_body);
            end
            ST_UPDATE:
            begin
                mem_ctl.body_we = 1'b1;
                body_addr       = body_idx_reg;
            end
            ST_Q_RD:
            begin
                mem_ctl.body_re = 1'b1;
            end
            ST_Q_CHK:
            begin
                res_valid = 1'b0;
            end
            ST_SCAN:
            begin
                res_valid = gap && pend_valid_reg;
            end
            ST_FIN:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (!pend_valid_reg)
                begin
                    res.gap_section = '0;
                    res.gap_found   = 1'b0;
                end
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_AW'(1);
            end
            if (state_reg == ST_Q_CHK)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN && step_go && gap)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_valid)
        begin
            item_reg <= item;
        end
        if (state_reg == ST_BODY_RD)
        begin
            body_idx_reg <= BODY_AW'(rec_body);
        end
        if (state_reg == ST_Q_CHK)
        begin
            bits_reg <= ent_bits;
            z_reg    <= ent_lo;
            hi_reg   <= ent_hi;
        end
        if (state_reg == ST_SCAN && step_go)
        begin
            if (gap)
            begin
                pend_reg <= z_reg;
            end
            if (z_reg != hi_reg)
            begin
                z_reg <= z_reg + SEC_FW'(1);
            end
        end
    end

endmodule

@@ hdl/body_section_gap_finder_unit.sv @@
// top level of the body section gap finder with the result register
//
//  channel | direction | handshake                   | payload
//  item    | in        | item_valid / item_stall     | in_item_t
//  result  | out       | result_valid / result_stall | out_item_t
//
// after reset a clearing pass over max(SEGMENTS, BODIES) addresses (1024 by default)
// zeroes both tables; item_stall stays high during it
// load: segment table write; record: table read, record read, record write if in range
// query: record read, then a scan from lo to hi of one section per cycle, held while a
// gap waits on a full result register; a body never recorded gives one result
// result_stall holds the sequencer only while a result waits on a full result register
module body_section_gap_finder_unit #(
    parameter int SECTIONS = bsgf_pkg::SECTIONS_DEF,
    parameter int BODIES   = bsgf_pkg::BODIES_DEF,
    parameter int SEGMENTS = bsgf_pkg::SEGMENTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  bsgf_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output bsgf_pkg::out_item_t result
);
    import bsgf_pkg::*;

    localparam int SEG_AW  = $clog2(SEGMENTS);
    localparam int BODY_AW = $clog2(BODIES);
    localparam int ENT_W   = SECTIONS + 2 * SEC_FW + 1;

    mem_ctl_t           mem_ctl;
    logic [SEG_AW-1:0]  seg_addr;
    logic [BODY_FW-1:0] seg_wdata;
    logic [BODY_FW-1:0] seg_rdata;
    logic [BODY_AW-1:0] body_addr;
    logic [ENT_W-1:0]   body_wdata;
    logic [ENT_W-1:0]   body_rdata;
    logic               res_valid;
    logic               res_ready;
    out_item_t          res;
    logic               result_valid_reg;
    out_item_t          result_reg;

    // sequencer
    bsgf_ctrl #(
        .SECTIONS (SECTIONS),
        .BODIES   (BODIES),
        .SEGMENTS (SEGMENTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_ctl    (mem_ctl),
        .seg_addr   (seg_addr),
        .seg_wdata  (seg_wdata),
        .seg_rdata  (seg_rdata),
        .body_addr  (body_addr),
        .body_wdata (body_wdata),
        .body_rdata (body_rdata)
    );

    // tables
    bsgf_mem #(
        .SECTIONS (SECTIONS),
        .BODIES   (BODIES),
        .SEGMENTS (SEGMENTS)
    ) u_mem (
        .clk        (clk),
        .ctl        (mem_ctl),
        .seg_addr   (seg_addr),
        .seg_wdata  (seg_wdata),
        .seg_rdata  (seg_rdata),
        .body_addr  (body_addr),
        .body_wdata (body_wdata),
        .body_rdata (body_rdata)
    );

    // result register takes a new transaction when empty or being drained
    assign res_ready = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            result_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // no result is produced while the sequencer is taking transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_stall |-> !res_valid)
        else $error("result offered while idle");

    // a result held back by the output side is offered again
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("pending result dropped");

    // a no-gap result closes its query
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.gap_found |-> result.last)
        else $error("no-gap result without last");

    // a no-gap result reports section zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.gap_found |-> result.gap_section == '0)
        else $error("no-gap result with nonzero section");

endmodule

@@ bench/tb_body_section_gap_finder_unit.sv @@
// testbench for the body section gap finder: directed and random transactions checked in order
`timescale 1ns / 100ps

module tb_body_section_gap_finder_unit;

    import bsgf_pkg::*;

    localparam int RANDOM_ITEMS = 88;
    localparam int CALM_TAIL    = 15;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int SEG_POOL     = 16;
    localparam int BODY_POOL    = 8;

    // action code the block ignores
    localparam logic [ACT_FW-1:0] ACT_SPARE = 2'd3;

    // tracks body presence per section and holds the gap runs still owed by the block
    class body_gap_tracker;
        logic [BODY_FW-1:0]      seg_body   [SEGMENTS_DEF];
        logic [SECTIONS_DEF-1:0] sec_bits   [BODIES_DEF];
        logic [SEC_FW-1:0]       lo_sec     [BODIES_DEF];
        logic [SEC_FW-1:0]       hi_sec     [BODIES_DEF];
        bit                      recorded   [BODIES_DEF];
        out_item_t               gaps_due   [$];
        int                      errors;

        function new();
            foreach (seg_body[i])
                seg_body[i] = '0;
            foreach (sec_bits[i])
            begin
                sec_bits[i] = '0;
                lo_sec[i]   = '0;
                hi_sec[i]   = '0;
                recorded[i] = 1'b0;
            end
            errors = 0;
        endfunction

        // append a result to the tail of the owed list
        function void owe_result(out_item_t r);
            gaps_due.insert(gaps_due.size(), r);
        endfunction

        // update the tables for an accepted transaction and queue any results it causes
        function void note_item(in_item_t it);
            logic [BODY_FW-1:0] b;
            out_item_t          r;
            bit                 have;
            int                 z;
            b    = '0;
            r    = '0;
            have = 1'b0;
            case (it.action)
                ACT_LOAD:
                    seg_body[it.segment_id] = it.body_id;
                ACT_RECORD:
                begin
                    b = seg_body[it.segment_id];
                    sec_bits[b][it.section] = 1'b1;
                    if (!recorded[b])
                    begin
                        recorded[b] = 1'b1;
                        lo_sec[b]   = it.section;
                        hi_sec[b]   = it.section;
                    end
                    else
                    begin
                        if (it.section < lo_sec[b])
                            lo_sec[b] = it.section;
                        if (it.section > hi_sec[b])
                            hi_sec[b] = it.section;
                    end
                end
                ACT_QUERY:
                begin
                    b = it.body_id;
                    if (recorded[b])
                    begin
                        // scan the recorded range, one result per missing section
                        for (z = lo_sec[b]; z <= hi_sec[b]; z++)
                        begin
                            if (!sec_bits[b][z])
                            begin
                                if (have)
                                    owe_result(r);
                                r.gap_section = SEC_FW'(z);
                                r.gap_body    = b;
                                r.gap_found   = 1'b1;
                                r.last        = 1'b0;
                                have          = 1'b1;
                            end
                        end
                    end
                    // no gap or never recorded: a single empty result
                    if (!have)
                    begin
                        r.gap_section = '0;
                        r.gap_body    = b;
                        r.gap_found   = 1'b0;
                    end
                    r.last = 1'b1;
                    owe_result(r);
                end
                default:
                    ;
            endcase
        endfunction

        // compare an accepted result with the oldest one owed
        function void check_result(out_item_t got);
            out_item_t want;
            if (gaps_due.size() == 0)
            begin
                $error("unexpected result: gap_section %0d gap_body %0d gap_found %0d last %0d",
                       got.gap_section, got.gap_body, got.gap_found, got.last);
                errors++;
                return;
            end
            want = gaps_due.pop_front();
            if (got.gap_section !== want.gap_section)
            begin
                $error("gap_section: expected %0d, actual %0d", want.gap_section, got.gap_section);
                errors++;
            end
            if (got.gap_body !== want.gap_body)
            begin
                $error("gap_body: expected %0d, actual %0d", want.gap_body, got.gap_body);
                errors++;
            end
            if (got.gap_found !== want.gap_found)
            begin
                $error("gap_found: expected %0d, actual %0d", want.gap_found, got.gap_found);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return gaps_due.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    body_gap_tracker gap_sb;
    bit              calm;
    bit              hold_req;

    logic [SEG_FW-1:0]  seg_pool  [SEG_POOL];
    logic [BODY_FW-1:0] body_pool [BODY_POOL];

    body_section_gap_finder_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_item_t mk_item(logic [ACT_FW-1:0] act, int sec, int seg, int body);
        in_item_t it;
        it.action     = act;
        it.section    = SEC_FW'(sec);
        it.segment_id = SEG_FW'(seg);
        it.body_id    = BODY_FW'(body);
        return it;
    endfunction

    // random transaction, mostly over a small set of segments and bodies so queries hit
    function automatic in_item_t random_item();
        int       pick;
        in_item_t it;
        pick          = $urandom_range(0, 99);
        it.section    = SEC_FW'($urandom_range(0, 63));
        it.segment_id = SEG_FW'($urandom_range(0, 1023));
        it.body_id    = BODY_FW'($urandom_range(0, 255));
        if (pick < 20)
        begin
            it.action = ACT_LOAD;
            if ($urandom_range(0, 9) != 0)
                it.segment_id = seg_pool[$urandom_range(0, SEG_POOL - 1)];
            if ($urandom_range(0, 9) != 0)
                it.body_id = body_pool[$urandom_range(0, BODY_POOL - 1)];
        end
        else if (pick < 65)
        begin
            it.action = ACT_RECORD;
            if ($urandom_range(0, 7) != 0)
                it.segment_id = seg_pool[$urandom_range(0, SEG_POOL - 1)];
        end
        else if (pick < 95)
        begin
            it.action = ACT_QUERY;
            if ($urandom_range(0, 7) != 0)
                it.body_id = body_pool[$urandom_range(0, BODY_POOL - 1)];
        end
        else
        begin
            it.action = ACT_SPARE;
        end
        return it;
    endfunction

    // offer one transaction from a falling edge and hold it until accepted
    task automatic send_item(in_item_t it);
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        gap_sb.note_item(it);
        @(negedge clk);
    endtask

    // drop valid for a random burst of cycles
    task automatic sender_gap();
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
    endtask

    // reset, directed transactions, then the random run
    initial
    begin
        int       counted;
        in_item_t it;
        gap_sb     = new();
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        foreach (seg_pool[i])
            seg_pool[i] = SEG_FW'($urandom_range(0, 1023));
        foreach (body_pool[i])
            body_pool[i] = BODY_FW'($urandom_range(0, 255));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // body never recorded, then an ignored action with all fields high
        send_item(mk_item(ACT_QUERY, 0, 0, 0));
        send_item(mk_item(ACT_SPARE, 63, 1023, 255));
        // widest range: sections 0 and 63 on the top body
        send_item(mk_item(ACT_LOAD, 0, 1023, 255));
        send_item(mk_item(ACT_RECORD, 63, 1023, 0));
        send_item(mk_item(ACT_RECORD, 0, 1023, 0));
        send_item(mk_item(ACT_QUERY, 0, 0, 255));
        // single section: range with no gap, then a second section opens gaps
        send_item(mk_item(ACT_LOAD, 0, 512, 85));
        send_item(mk_item(ACT_RECORD, 21, 512, 0));
        send_item(mk_item(ACT_QUERY, 0, 0, 85));
        send_item(mk_item(ACT_RECORD, 42, 512, 0));
        send_item(mk_item(ACT_QUERY, 0, 0, 85));
        // unmapped segments fall to body 0
        send_item(mk_item(ACT_RECORD, 10, 341, 0));
        send_item(mk_item(ACT_RECORD, 12, 682, 0));
        send_item(mk_item(ACT_QUERY, 0, 0, 0));
        send_item(mk_item(ACT_QUERY, 0, 0, 170));
        // fill inside a range, then remap a segment to another body
        send_item(mk_item(ACT_RECORD, 30, 1023, 0));
        send_item(mk_item(ACT_QUERY, 0, 0, 255));
        send_item(mk_item(ACT_LOAD, 0, 1023, 0));
        send_item(mk_item(ACT_RECORD, 5, 1023, 0));
        send_item(mk_item(ACT_QUERY, 0, 0, 0));

        // random run; the receiver starts with a long hold-off
        hold_req = 1'b1;
        counted  = 0;
        while (counted < RANDOM_ITEMS)
        begin
            it = random_item();
            if (it.action != ACT_SPARE)
                counted++;
            calm = (counted > RANDOM_ITEMS - CALM_TAIL);
            if (!calm && $urandom_range(0, 4) == 0)
                sender_gap();
            send_item(it);
        end
        item_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (gap_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (gap_sb.errors == 0)
            $display("** body_section_gap_finder_unit: PASSED **");
        else
            $display("** body_section_gap_finder_unit: FAILED **");
        $finish;
    end

    // result side: random stall bursts, one long hold-off, sample at the rising edge
    initial
    begin
        int stall_left;
        bit held;
        result_stall = 1'b0;
        stall_left   = 0;
        held         = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
            end
            @(posedge clk);
            if (result_valid && !result_stall)
                gap_sb.check_result(result);
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("** body_section_gap_finder_unit: FAILED **");
                $finish;
            end
        end
    end

endmodule
